// ----- src/srtp_pkg.sv -----
// shared types, codes and helpers for the report tpdu parser
package srtp_pkg;

  // field labels, also the phase codes of the classifier
  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_IND   = 3'd1,
    PH_STAMP = 3'd2,
    PH_PID   = 3'd3,
    PH_DCS   = 3'd4,
    PH_UDL   = 3'd5,
    PH_UD    = 3'd6,
    PH_IGN   = 3'd7
  } phase_e;

  localparam int unsigned StampLen   = 7;
  localparam int unsigned StampW     = 3;
  localparam int unsigned IndW       = 3;
  localparam int unsigned TypeW      = 2;
  localparam int unsigned OctetW     = 8;
  localparam int unsigned TypeMask   = 8'h03;
  localparam int unsigned HdrBit     = 6;
  localparam int unsigned IndPidBit  = 0;
  localparam int unsigned IndDcsBit  = 1;
  localparam int unsigned IndUdlBit  = 2;
  localparam logic [TypeW-1:0] SubmitTypeRst = 2'd1;
  localparam logic [StampW-1:0] StampLast = StampW'(StampLen - 1);

  // one labelled beat
  typedef struct packed {
    phase_e              kind;
    logic [OctetW-1:0]   value;
    logic [StampW-1:0]   stamp_idx;
    logic [TypeW-1:0]    msg_type;
    logic                hdr_flag;
    logic                too_short;
    logic                done;
  } result_t;

  // next enabled field once everything up to 'from' is consumed
  function automatic phase_e next_field(phase_e from, logic [IndW-1:0] ind);
    phase_e res;
    res = PH_IGN;
    if (from < PH_PID && ind[IndPidBit]) begin
      res = PH_PID;
    end else if (from < PH_DCS && ind[IndDcsBit]) begin
      res = PH_DCS;
    end else if (from < PH_UDL && ind[IndUdlBit]) begin
      res = PH_UDL;
    end
    return res;
  endfunction

endpackage

// ----- src/srtp_front.sv -----
// classifier: phase machine that labels each incoming octet
module srtp_front import srtp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TypeW-1:0]  cfg_wdata_i,
  input  logic              fire_i,
  input  logic [OctetW-1:0] octet_i,
  input  logic              final_octet_i,
  output result_t           res_o
);

  phase_e              phase_q, phase_d, nxt;
  logic [StampW-1:0]   stamp_q, stamp_d;
  logic [IndW-1:0]     ind_q, ind_d;
  logic [TypeW-1:0]    type_q, type_d;
  logic                hdr_q, hdr_d;
  logic [TypeW-1:0]    submit_type_q;
  logic                shrt;
  logic [StampW-1:0]   sidx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      submit_type_q <= SubmitTypeRst;
    end else if (cfg_we_i) begin
      submit_type_q <= cfg_wdata_i;
    end
  end

  // label and field updates for the current phase
  always_comb begin
    nxt     = PH_IGN;
    shrt    = 1'b0;
    sidx    = '0;
    stamp_d = stamp_q;
    ind_d   = ind_q;
    type_d  = type_q;
    hdr_d   = hdr_q;
    unique case (phase_q)
      PH_FIRST: begin
        type_d  = octet_i[TypeW-1:0];
        hdr_d   = octet_i[HdrBit];
        ind_d   = '0;
        stamp_d = '0;
        shrt    = 1'b1;
        nxt     = PH_IND;
      end
      PH_IND: begin
        ind_d   = octet_i[IndW-1:0];
        stamp_d = '0;
        shrt    = 1'b1;
        nxt     = (type_q == submit_type_q) ? PH_STAMP
                                            : next_field(PH_STAMP, octet_i[IndW-1:0]);
      end
      PH_STAMP: begin
        sidx = stamp_q;
        if (stamp_q < StampLast) begin
          shrt    = 1'b1;
          stamp_d = stamp_q + StampW'(1);
          nxt     = PH_STAMP;
        end else begin
          shrt    = |ind_q;
          stamp_d = '0;
          nxt     = next_field(PH_STAMP, ind_q);
        end
      end
      PH_PID: begin
        shrt = 1'b1;
        nxt  = next_field(PH_PID, ind_q);
      end
      PH_DCS: begin
        shrt = 1'b1;
        nxt  = next_field(PH_DCS, ind_q);
      end
      PH_UDL:  nxt = PH_UD;
      PH_UD:   nxt = PH_UD;
      PH_IGN:  nxt = PH_IGN;
      default: nxt = PH_IGN;
    endcase
    // a final byte restarts the tpdu
    if (final_octet_i) begin
      stamp_d = '0;
    end else begin
      shrt = 1'b0;
    end
  end

  // next phase
  always_comb begin
    phase_d = final_octet_i ? PH_FIRST : nxt;
  end

  always_comb begin
    res_o.kind      = phase_q;
    res_o.value     = octet_i;
    res_o.stamp_idx = sidx;
    res_o.msg_type  = type_d;
    res_o.hdr_flag  = hdr_d;
    res_o.too_short = shrt;
    res_o.done      = final_octet_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      stamp_q <= '0;
      ind_q   <= '0;
      type_q  <= '0;
      hdr_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      stamp_q <= stamp_d;
      ind_q   <= ind_d;
      type_q  <= type_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

// ----- src/srtp_fifo.sv -----
// two-entry queue between classifier and output stage
module srtp_fifo import srtp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t wdata_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t rdata_o
);

  result_t     mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

endmodule

// ----- src/srtp_back.sv -----
// output stage: holds one labelled beat until the sink takes it
module srtp_back import srtp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  result_t q_data_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- src/sms_report_tpdu_parser.sv -----
// top level of the sms deliver/submit report tpdu octet labeller
//
//   port group         dir  handshake                 beat contents
//   in_*  / octet      in   in_valid_i / in_ready_o   octet_i, final_octet_i
//   out_* / field_*    out  out_valid_o / out_ready_i field, stamp, type, flags
//   cfg_*              in   cfg_we_i (no wait)        submit report type code
//
// one octet accepted per cycle while in_ready_o is high; its result passes the queue
// and the output stage; the classifier's phase machine labels an octet combinationally
// reset clears phase, held fields, queue and output stage; config goes to 1
// a stalled sink fills the output stage and the two-entry queue, then in_ready_o drops
module sms_report_tpdu_parser import srtp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TypeW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OctetW-1:0] octet_i,
  input  logic              final_octet_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        field_kind_o,
  output logic [OctetW-1:0] field_value_o,
  output logic [StampW-1:0] stamp_index_o,
  output logic [TypeW-1:0]  msg_type_o,
  output logic              header_flag_o,
  output logic              too_short_o,
  output logic              tpdu_done_o
);

  logic    fire;
  logic    q_full, q_valid, q_pop;
  result_t front_res, q_data, out_data;

  // accept whenever the queue has room, independent of the sink
  assign in_ready_o = !q_full;
  assign fire       = in_valid_i && in_ready_o;

  // front: label the beat and advance the phase
  srtp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fire_i        (fire),
    .octet_i       (octet_i),
    .final_octet_i (final_octet_i),
    .res_o         (front_res)
  );

  // decoupling queue
  srtp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .wdata_i (front_res),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_data)
  );

  // back: registered output toward the sink
  srtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  // unpack the beat onto the field ports
  assign field_kind_o  = out_data.kind;
  assign field_value_o = out_data.value;
  assign stamp_index_o = out_data.stamp_idx;
  assign msg_type_o    = out_data.msg_type;
  assign header_flag_o = out_data.hdr_flag;
  assign too_short_o   = out_data.too_short;
  assign tpdu_done_o   = out_data.done;

endmodule

// ----- verif/tb_sms_report_tpdu_parser.sv -----
// testbench for the report tpdu parser: directed and random octet streams checked by a predictor
`timescale 1ns / 1ps

module tb_sms_report_tpdu_parser;
  import srtp_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 8;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems  = 230;
  localparam int NumPhases   = 6;
  localparam int StallAt     = 400;   // items accepted before the long sink hold-off
  localparam int StallCycles = 300;
  localparam int SteadyLo    = 700;   // window with no idling on either side
  localparam int SteadyHi    = 900;
  localparam int IdlePct     = 24;
  localparam int PrintCap    = 50;

  // label predictor and per-field check of the labelled beats
  class tpdu_scoreboard;
    logic [TypeW-1:0]  report_type;
    phase_e            cur_field;
    logic [StampW-1:0] stamp_cnt;
    logic [IndW-1:0]   ind_bits;
    logic [TypeW-1:0]  held_type;
    logic              held_hdr;
    result_t           label_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       short_seen;
    int unsigned       stamps_seen;

    function void clear_state();
      report_type = SubmitTypeRst;
      cur_field   = PH_FIRST;
      stamp_cnt   = '0;
      ind_bits    = '0;
      held_type   = '0;
      held_hdr    = 1'b0;
      errors      = 0;
      checked     = 0;
      short_seen  = 0;
      stamps_seen = 0;
      label_q.delete();
    endfunction

    // first optional field past 'past' whose indicator bit is set
    function phase_e next_enabled(phase_e past);
      phase_e cand;
      for (int k = 0; k < IndW; k++) begin
        cand = phase_e'(PH_PID + k);
        if (cand > past && ind_bits[k]) return cand;
      end
      return PH_IGN;
    endfunction

    // label one accepted input beat and queue the expected result
    function void note_octet(logic [OctetW-1:0] b, logic fin);
      result_t want;
      phase_e  nxt;
      want.kind      = cur_field;
      want.value     = b;
      want.stamp_idx = '0;
      want.too_short = 1'b0;
      nxt = PH_IGN;
      case (cur_field)
        PH_FIRST: begin
          held_type      = b[TypeW-1:0];
          held_hdr       = b[HdrBit];
          ind_bits       = '0;
          stamp_cnt      = '0;
          want.too_short = 1'b1;
          nxt = PH_IND;
        end
        PH_IND: begin
          // the register counts only from here on
          ind_bits       = b[IndW-1:0];
          stamp_cnt      = '0;
          want.too_short = 1'b1;
          nxt = (held_type == report_type) ? PH_STAMP : next_enabled(PH_STAMP);
        end
        PH_STAMP: begin
          want.stamp_idx = stamp_cnt;
          if (stamp_cnt != StampLast) begin
            want.too_short = 1'b1;
            stamp_cnt      = stamp_cnt + 3'd1;
            nxt = PH_STAMP;
          end else begin
            // seventh stamp ends the pdu cleanly only when nothing else is enabled
            want.too_short = |ind_bits;
            stamp_cnt      = '0;
            nxt = next_enabled(PH_STAMP);
          end
        end
        PH_PID, PH_DCS: begin
          want.too_short = 1'b1;
          nxt = next_enabled(cur_field);
        end
        PH_UDL, PH_UD: nxt = PH_UD;
        default:       nxt = PH_IGN;
      endcase
      if (fin) begin
        cur_field = PH_FIRST;
        stamp_cnt = '0;
      end else begin
        cur_field      = nxt;
        want.too_short = 1'b0;
      end
      want.msg_type = held_type;
      want.hdr_flag = held_hdr;
      want.done     = fin;
      label_q.push_back(want);
    endfunction

    task report_mismatch(string what, logic [7:0] got_v, logic [7:0] want_v);
      if (errors < PrintCap)
        $display("mismatch at beat %0d: %s got %h expected %h", checked, what, got_v, want_v);
      errors++;
    endtask

    // compare one output beat with the oldest label
    task check_result(result_t got);
      result_t want;
      if (label_q.size() == 0) begin
        report_mismatch("beat with no label pending, field_value", got.value, 8'h00);
      end else begin
        want = label_q.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("field_kind", 8'(got.kind), 8'(want.kind));
        if (got.value !== want.value)
          report_mismatch("field_value", got.value, want.value);
        if (got.stamp_idx !== want.stamp_idx)
          report_mismatch("stamp_index", 8'(got.stamp_idx), 8'(want.stamp_idx));
        if (got.msg_type !== want.msg_type)
          report_mismatch("msg_type", 8'(got.msg_type), 8'(want.msg_type));
        if (got.hdr_flag !== want.hdr_flag)
          report_mismatch("header_flag", 8'(got.hdr_flag), 8'(want.hdr_flag));
        if (got.too_short !== want.too_short)
          report_mismatch("too_short", 8'(got.too_short), 8'(want.too_short));
        if (got.done !== want.done)
          report_mismatch("tpdu_done", 8'(got.done), 8'(want.done));
        if (want.too_short) short_seen++;
        if (want.kind == PH_STAMP) stamps_seen++;
      end
      checked++;
    endtask
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [TypeW-1:0]  cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [OctetW-1:0] octet_i       = '0;
  logic              final_octet_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [2:0]        field_kind_o;
  logic [OctetW-1:0] field_value_o;
  logic [StampW-1:0] stamp_index_o;
  logic [TypeW-1:0]  msg_type_o;
  logic              header_flag_o;
  logic              too_short_o;
  logic              tpdu_done_o;

  tpdu_scoreboard    sb;
  logic [7:0]        tpdu_q[$];     // octets of the pdu being sent
  int unsigned       item_cnt  = 0;
  int unsigned       tpdu_cnt  = 0;
  int unsigned       cycle_cnt = 0;
  logic [3:0]        type_used = '0;

  sms_report_tpdu_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .octet_i       (octet_i),
    .final_octet_i (final_octet_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_kind_o  (field_kind_o),
    .field_value_o (field_value_o),
    .stamp_index_o (stamp_index_o),
    .msg_type_o    (msg_type_o),
    .header_flag_o (header_flag_o),
    .too_short_o   (too_short_o),
    .tpdu_done_o   (tpdu_done_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // offer one input beat and wait for its handshake
  task automatic send_octet(logic [7:0] b, logic fin);
    @(negedge clk_i);
    if (!(item_cnt >= SteadyLo && item_cnt < SteadyHi)) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    octet_i       <= b;
    final_octet_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_octet(b, fin);
    item_cnt++;
    if (fin) tpdu_cnt++;
  endtask

  // send part of the current pdu, the final mark going on its last octet
  task automatic send_span(int from, int upto);
    for (int i = from; i < upto; i++)
      send_octet(tpdu_q[i], i == tpdu_q.size() - 1);
  endtask

  // stop offering and wait for every labelled beat to come out
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.label_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_report_type(logic [TypeW-1:0] v);
    quiesce();
    @(negedge clk_i);
    cfg_we_i       <= 1'b1;
    cfg_wdata_i    <= v;
    sb.report_type = v;
    type_used[v]   = 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one random pdu: mostly well formed, some cut short, some plain noise
  function automatic void build_tpdu();
    int unsigned mode;
    int unsigned cut;
    logic [7:0]  first;
    logic [7:0]  ind;
    bit          has_stamps;
    tpdu_q.delete();
    mode = $urandom_range(0, 99);
    if (mode < 15) begin
      repeat ($urandom_range(1, 12)) tpdu_q.push_back(8'($urandom));
      return;
    end
    first = 8'($urandom);
    if ($urandom_range(0, 99) < 60) first[TypeW-1:0] = sb.report_type;
    ind = 8'($urandom);
    has_stamps = (first[TypeW-1:0] == sb.report_type);
    tpdu_q.push_back(first);
    tpdu_q.push_back(ind);
    if (has_stamps) repeat (StampLen) tpdu_q.push_back(8'($urandom));
    if (ind[IndPidBit]) tpdu_q.push_back(8'($urandom));
    if (ind[IndDcsBit]) tpdu_q.push_back(8'($urandom));
    if (ind[IndUdlBit]) begin
      tpdu_q.push_back(8'($urandom));
      repeat ($urandom_range(0, 8)) tpdu_q.push_back(8'($urandom));
    end else begin
      // trailing bytes with no length field are just ignored
      repeat ($urandom_range(0, 3)) tpdu_q.push_back(8'($urandom));
    end
    if (mode < 35) begin
      // cut at the seventh stamp half the time, anywhere otherwise
      if (has_stamps && $urandom_range(0, 1)) cut = 2 + StampLen;
      else cut = $urandom_range(1, tpdu_q.size());
      while (tpdu_q.size() > cut) void'(tpdu_q.pop_back());
    end
  endfunction

  // output side: random back-pressure, one long hold-off, check every beat
  initial begin : sink
    bit      held_off;
    logic    rdy;
    result_t got;
    held_off = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held_off && item_cnt >= StallAt) begin
        // sender keeps offering, so the queue fills and input ready drops
        out_ready_i <= 1'b0;
        repeat (StallCycles) @(negedge clk_i);
        held_off = 1'b1;
      end
      if (sb.checked >= SteadyLo && sb.checked < SteadyHi) rdy = 1'b1;
      else rdy = ($urandom_range(0, 99) >= IdlePct);
      out_ready_i <= rdy;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.kind      = phase_e'(field_kind_o);
        got.value     = field_value_o;
        got.stamp_idx = stamp_index_o;
        got.msg_type  = msg_type_o;
        got.hdr_flag  = header_flag_o;
        got.too_short = too_short_o;
        got.done      = tpdu_done_o;
        sb.check_result(got);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d labels still pending", cycle_cnt, sb.label_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    logic [8:0]       directed_seq [29];   // bit 8 is the final mark
    logic [TypeW-1:0] type_plan [4];
    logic [TypeW-1:0] new_type;
    int unsigned      phase_end;
    int               split;
    sb = new;
    sb.clear_state();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, report type still at its reset code
    directed_seq = '{
      9'h1FF,                                  // final on the first octet
      9'h0BC, 9'h1F8,                          // final on the indicator
      9'h041, 9'h006, 9'h011, 9'h022, 9'h133,  // stamps cut early
      9'h001, 9'h000, 9'h010, 9'h020, 9'h030,  // full stamp run, nothing after
      9'h040, 9'h050, 9'h060, 9'h170,
      9'h000, 9'h003, 9'h1FF,                  // final on protocol id
      9'h003, 9'h004, 9'h080, 9'h055, 9'h1AA,  // length and user data
      9'h000, 9'h000, 9'h012, 9'h134           // ignored tail
    };
    foreach (directed_seq[i]) send_octet(directed_seq[i][7:0], directed_seq[i][8]);

    // random part, one report type per phase, extremes first
    type_plan = '{2'd3, 2'd0, 2'd2, 2'd1};
    for (int p = 0; p < NumPhases; p++) begin
      phase_end = item_cnt + PhaseItems;
      new_type  = (p < 4) ? type_plan[p] : TypeW'($urandom);
      build_tpdu();
      // sometimes the register moves between the first octet and the indicator
      split = 0;
      if (tpdu_q.size() > 1 && $urandom_range(0, 1)) begin
        split = 1;
        send_span(0, 1);
      end
      write_report_type(new_type);
      send_span(split, tpdu_q.size());
      while (item_cnt < phase_end) begin
        build_tpdu();
        send_span(0, tpdu_q.size());
      end
    end

    quiesce();
    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d octets in %0d report tpdus, %0d labelled beats checked",
             item_cnt, tpdu_cnt, sb.checked);
    $display("%0d short-tpdu flags and %0d timestamp labels seen under %0d report type codes",
             sb.short_seen, sb.stamps_seen, $countones(type_used));
    if (sb.errors == 0 && sb.label_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d labels never matched", sb.errors, sb.label_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
